[rtl/ksss_pkg.sv]
// Shared types, constants and saturation helpers for the shifted sparse Kaczmarz sweep.
package ksss_pkg;

  // Default sizes
  localparam int MAX_ROWS_DEF     = 1024;
  localparam int MAX_NONZEROS_DEF = 4096;
  localparam int FRAC_BITS_DEF    = 16;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 13;
  localparam int CS_W   = 13;
  localparam int ER_W   = 10;
  localparam int VAL_W  = 32;
  localparam int FLT_W  = 2;
  localparam int RC_W   = 11;
  localparam int RLX_W  = 18;
  localparam int CFG_W  = 32;
  localparam int CIDX_W = 2;

  // Quotient width of the scaling divide: |s * omega| + |norm| / 2 stays below 2^50
  localparam int DIV_W  = 50;

  typedef enum logic [CMD_W-1:0] {
    CMD_COL_START = 3'd0,
    CMD_ENTRY     = 3'd1,
    CMD_ROW_DATA  = 3'd2,
    CMD_START_VEC = 3'd3,
    CMD_RUN       = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_ROW_COUNT  = 2'd0,
    REG_RELAXATION = 2'd1,
    REG_SHIFT_REAL = 2'd2,
    REG_SHIFT_IMAG = 2'd3
  } cfg_reg_t;

  // Packed memory words
  typedef struct packed {
    logic [VAL_W-1:0] rhs_re;
    logic [VAL_W-1:0] rhs_im;
    logic [VAL_W-1:0] mass;
    logic [VAL_W-1:0] norm;
  } row_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] re;
    logic [VAL_W-1:0] im;
  } sol_word_t;

  typedef struct packed {
    logic [ER_W-1:0]  row;
    logic [VAL_W-1:0] val;
  } ent_word_t;

  // Multiplier request / response
  typedef struct packed {
    logic             start;
    logic             raw;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [VAL_W-1:0] res;
    logic [63:0]      prod;
  } mul_rsp_t;

  // Divider request / response
  typedef struct packed {
    logic             start;
    logic [63:0]      num;
    logic [VAL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [VAL_W-1:0] res;
  } div_rsp_t;

  // Clamp a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

endpackage

[rtl/ksss_in_if.sv]
// Input channel: command items with load payloads.
interface ksss_in_if;
  logic                              valid;
  logic                              ready;
  logic [ksss_pkg::CMD_W-1:0]        command;
  logic [ksss_pkg::IDX_W-1:0]        index;
  logic [ksss_pkg::CS_W-1:0]         col_start;
  logic [ksss_pkg::ER_W-1:0]         entry_row;
  logic signed [ksss_pkg::VAL_W-1:0] entry_value;
  logic signed [ksss_pkg::VAL_W-1:0] rhs_re;
  logic signed [ksss_pkg::VAL_W-1:0] rhs_im;
  logic signed [ksss_pkg::VAL_W-1:0] mass_diag;
  logic signed [ksss_pkg::VAL_W-1:0] row_norm_sq;
  logic signed [ksss_pkg::VAL_W-1:0] start_re;
  logic signed [ksss_pkg::VAL_W-1:0] start_im;

  modport source (
    output valid, command, index, col_start, entry_row, entry_value,
           rhs_re, rhs_im, mass_diag, row_norm_sq, start_re, start_im,
    input  ready
  );
  modport sink (
    input  valid, command, index, col_start, entry_row, entry_value,
           rhs_re, rhs_im, mass_diag, row_norm_sq, start_re, start_im,
    output ready
  );
endinterface

[rtl/ksss_out_if.sv]
// Output channel: one result per accepted command.
interface ksss_out_if;
  logic                              valid;
  logic                              ready;
  logic [ksss_pkg::IDX_W-1:0]        result_index;
  logic signed [ksss_pkg::VAL_W-1:0] result_x_re;
  logic signed [ksss_pkg::VAL_W-1:0] result_x_im;
  logic                              sweep_done;
  logic [ksss_pkg::FLT_W-1:0]        fault_flags;

  modport source (
    output valid, result_index, result_x_re, result_x_im, sweep_done, fault_flags,
    input  ready
  );
  modport sink (
    input  valid, result_index, result_x_re, result_x_im, sweep_done, fault_flags,
    output ready
  );
endinterface

[rtl/kaczmarz_sweep_shifted_sparse.sv]
// Symmetric Kaczmarz sweep engine for (A - sigma*B) x = b in signed fixed point.
// Load and read commands follow back to back while the output channel takes each result. A run
// command keeps the input stalled for one forward and one backward pass over the active rows;
// every product goes through the single shared multiplier and each row's two scaling quotients
// through the bit-serial divider. A row with a zero norm is skipped, as is each nonzero whose row
// index is not below the active row count.
module kaczmarz_sweep_shifted_sparse #(
  parameter int MAX_ROWS     = ksss_pkg::MAX_ROWS_DEF,
  parameter int MAX_NONZEROS = ksss_pkg::MAX_NONZEROS_DEF,
  parameter int FRAC_BITS    = ksss_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ksss_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [ksss_pkg::CFG_W-1:0]    cfg_data,
  ksss_in_if.sink                       in_ch,
  ksss_out_if.source                    out_ch
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int NW = $clog2(MAX_NONZEROS);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_ROW_A = 12'b000000000010,
    S_ROW_B = 12'b000000000100,
    S_ROW_C = 12'b000000001000,
    S_PRE   = 12'b000000010000,
    S_EA    = 12'b000000100000,
    S_EB    = 12'b000001000000,
    S_EC    = 12'b000010000000,
    S_ED    = 12'b000100000000,
    S_SCALE = 12'b001000000000,
    S_UPD   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  // Configuration
  logic [ksss_pkg::RC_W-1:0]  row_count;
  logic [ksss_pkg::RLX_W-1:0] relaxation;
  logic signed [31:0]         shift_real, shift_imag;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= ksss_pkg::RC_W'(1);
      relaxation <= ksss_pkg::RLX_W'(65536);
      shift_real <= '0;
      shift_imag <= '0;
    end else if (cfg_write) begin
      case (ksss_pkg::cfg_reg_t'(cfg_index))
        ksss_pkg::REG_ROW_COUNT:  row_count  <= cfg_data[ksss_pkg::RC_W-1:0];
        ksss_pkg::REG_RELAXATION: relaxation <= cfg_data[ksss_pkg::RLX_W-1:0];
        ksss_pkg::REG_SHIFT_REAL: shift_real <= cfg_data;
        ksss_pkg::REG_SHIFT_IMAG: shift_imag <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control and working registers
  state_t             state;
  logic [12:0]        idx_reg;
  logic [RW:0]        n_rows, row_i;
  logic               fwd, scat, op_busy;
  logic [2:0]         k;
  logic [NW:0]        j, lo, hi;
  logic [12:0]        lo_raw;
  logic signed [31:0] rhs_re, rhs_im, mass, norm;
  logic signed [31:0] x_re_i, x_im_i, sbr, sbi, sr, si;
  logic signed [63:0] acc_r, acc_i, num_reg;
  logic [9:0]         e_row;
  logic signed [31:0] e_val, xr, xi, u_tmp, nr_new;
  logic [1:0]         faults;

  // Output register
  logic        out_valid, out_is_read, out_done;
  logic [12:0] out_index;
  logic [1:0]  out_faults;
  logic        out_free;

  // Memories
  logic [ksss_pkg::CS_W-1:0] cs_mem  [MAX_ROWS+1];
  ksss_pkg::ent_word_t       ent_mem [MAX_NONZEROS];
  ksss_pkg::row_word_t       row_mem [MAX_ROWS];
  ksss_pkg::sol_word_t       sol_mem [MAX_ROWS];

  logic [ksss_pkg::CS_W-1:0] cs_q;
  ksss_pkg::ent_word_t       ent_q;
  ksss_pkg::row_word_t       row_q;
  ksss_pkg::sol_word_t       sol_q;

  logic                cs_we, cs_re, ent_we, ent_re, row_we, row_re, sol_we, sol_re;
  logic [CW-1:0]       cs_waddr, cs_raddr;
  logic [NW-1:0]       ent_addr_w, ent_raddr;
  logic [RW-1:0]       row_waddr, row_raddr, sol_waddr, sol_raddr;
  ksss_pkg::sol_word_t sol_wdata;

  // Handshake and decoded fields
  logic        in_fire;
  logic [31:0] idx32, rc32, n_eff32, row_i32, row_n32, j32, erow32;
  logic [RW:0] n_eff;
  logic        ld_row_ok, ld_cs_ok, ld_nz_ok, ent_ok;
  ksss_pkg::cmd_t cmd;

  // Shared units
  ksss_pkg::mul_req_t mul_req;
  ksss_pkg::mul_rsp_t mul_rsp;
  ksss_pkg::div_req_t div_req;
  ksss_pkg::div_rsp_t div_rsp;
  logic signed [31:0] mres, dres, row_norm_q, sc_in;
  logic               op_done, scale_sat, sat_hit, nz_hit;
  logic signed [63:0] upd_r_sum, upd_i_sum, sc_r_sum, sc_i_sum;

  // Row stepping
  logic        last_row, nxt_fwd;
  logic [RW:0] nxt_i;

  function automatic logic [NW:0] clamp_nz(input logic [12:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(MAX_NONZEROS)) begin
      w = 32'(MAX_NONZEROS);
    end
    return w[NW:0];
  endfunction

  assign cmd       = ksss_pkg::cmd_t'(in_ch.command);
  assign out_free  = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign idx32     = 32'(in_ch.index);
  assign ld_row_ok = idx32 < 32'(MAX_ROWS);
  assign ld_cs_ok  = idx32 <= 32'(MAX_ROWS);
  assign ld_nz_ok  = idx32 < 32'(MAX_NONZEROS);
  assign rc32      = 32'(row_count);
  assign n_eff32   = (rc32 > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : rc32;
  assign n_eff     = n_eff32[RW:0];
  assign row_i32   = 32'(row_i);
  assign row_n32   = row_i32 + 32'd1;
  assign j32       = 32'(j);
  assign erow32    = 32'(ent_q.row);
  assign ent_ok    = erow32 < 32'(n_rows);
  assign row_norm_q = row_q.norm;

  // Next row of the forward-then-backward order
  always_comb begin
    last_row = 1'b0;
    nxt_fwd  = fwd;
    nxt_i    = row_i;
    if (fwd) begin
      if (row_i + 1'b1 == n_rows) begin
        nxt_fwd = 1'b0;
      end else begin
        nxt_i = row_i + 1'b1;
      end
    end else begin
      last_row = (row_i == '0);
      nxt_i    = row_i - 1'b1;
    end
  end

  // Arithmetic unit results and sums
  assign mres      = mul_rsp.res;
  assign dres      = div_rsp.res;
  assign op_done   = mul_rsp.done || div_rsp.done;
  assign upd_r_sum = 64'(x_re_i) + 64'(u_tmp) + 64'(mres);
  assign upd_i_sum = 64'(x_im_i) + 64'(u_tmp) - 64'(mres);
  assign sc_r_sum  = 64'(xr) - 64'(mres);
  assign sc_i_sum  = 64'(xi) - 64'(mres);
  assign sc_in     = (k == 3'd0) ? ksss_pkg::sat32(acc_r) : ksss_pkg::sat32(acc_i);

  // Multiplier and divider operand selection
  always_comb begin
    mul_req     = '0;
    div_req     = '0;
    scale_sat   = 1'b0;
    div_req.num = num_reg;
    div_req.den = norm;
    case (state)
      S_PRE: begin
        mul_req.start = !op_busy;
        case (k)
          3'd0:    begin mul_req.a = shift_real; mul_req.b = mass;   end
          3'd1:    begin mul_req.a = shift_imag; mul_req.b = mass;   end
          3'd2:    begin mul_req.a = sbr;        mul_req.b = x_re_i; end
          3'd3:    begin mul_req.a = sbi;        mul_req.b = x_im_i; end
          3'd4:    begin mul_req.a = sbr;        mul_req.b = x_im_i; end
          default: begin mul_req.a = sbi;        mul_req.b = x_re_i; end
        endcase
      end
      S_ED: begin
        mul_req.start = !op_busy;
        if (scat) begin
          mul_req.a = (k == 3'd0) ? sr : si;
          mul_req.b = e_val;
        end else begin
          mul_req.a = e_val;
          mul_req.b = (k == 3'd0) ? xr : xi;
        end
      end
      S_SCALE: begin
        mul_req.start = !op_busy && !k[0];
        mul_req.raw   = 1'b1;
        mul_req.a     = sc_in;
        mul_req.b     = 32'(relaxation);
        div_req.start = !op_busy && k[0];
        scale_sat     = mul_req.start &&
                        ksss_pkg::ovf32((k == 3'd0) ? acc_r : acc_i);
      end
      S_UPD: begin
        mul_req.start = !op_busy;
        case (k)
          3'd0:    begin mul_req.a = sr; mul_req.b = sbr; end
          3'd1:    begin mul_req.a = si; mul_req.b = sbi; end
          3'd2:    begin mul_req.a = si; mul_req.b = sbr; end
          default: begin mul_req.a = sr; mul_req.b = sbi; end
        endcase
      end
      default: ;
    endcase
  end

  ksss_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  ksss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Fault sources this cycle
  always_comb begin
    sat_hit = (mul_rsp.done && mul_rsp.sat) || (div_rsp.done && div_rsp.sat) || scale_sat;
    if (state == S_UPD && mul_rsp.done && k == 3'd1) begin
      sat_hit = sat_hit || ksss_pkg::ovf32(upd_r_sum);
    end
    if (state == S_UPD && mul_rsp.done && k == 3'd3) begin
      sat_hit = sat_hit || ksss_pkg::ovf32(upd_i_sum);
    end
    if (state == S_ED && scat && mul_rsp.done) begin
      sat_hit = sat_hit ||
                ksss_pkg::ovf32((k == 3'd0) ? sc_r_sum : sc_i_sum);
    end
  end
  assign nz_hit = (state == S_ROW_B) && (row_norm_q == '0);

  // Memory port control
  always_comb begin
    cs_we      = 1'b0;
    cs_waddr   = idx32[CW-1:0];
    cs_re      = 1'b0;
    cs_raddr   = row_i32[CW-1:0];
    ent_we     = 1'b0;
    ent_addr_w = idx32[NW-1:0];
    ent_re     = 1'b0;
    ent_raddr  = j32[NW-1:0];
    row_we     = 1'b0;
    row_waddr  = idx32[RW-1:0];
    row_re     = 1'b0;
    row_raddr  = row_i32[RW-1:0];
    sol_we     = 1'b0;
    sol_waddr  = idx32[RW-1:0];
    sol_wdata  = {in_ch.start_re, in_ch.start_im};
    sol_re     = 1'b0;
    sol_raddr  = idx32[RW-1:0];
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd)
            ksss_pkg::CMD_COL_START: cs_we  = ld_cs_ok;
            ksss_pkg::CMD_ENTRY:     ent_we = ld_nz_ok;
            ksss_pkg::CMD_ROW_DATA:  row_we = ld_row_ok;
            ksss_pkg::CMD_START_VEC: sol_we = ld_row_ok;
            ksss_pkg::CMD_READ:      sol_re = ld_row_ok;
            default: ;
          endcase
        end
      end
      S_ROW_A: begin
        cs_re     = 1'b1;
        row_re    = 1'b1;
        sol_re    = 1'b1;
        sol_raddr = row_i32[RW-1:0];
      end
      S_ROW_B: begin
        cs_re    = 1'b1;
        cs_raddr = row_n32[CW-1:0];
      end
      S_EA: begin
        ent_re = j < hi;
      end
      S_EB: begin
        sol_re    = ent_ok;
        sol_raddr = erow32[RW-1:0];
      end
      S_ED: begin
        sol_we    = scat && mul_rsp.done && k == 3'd1;
        sol_waddr = 32'(e_row) < 32'(MAX_ROWS) ? erow32_reg_addr(e_row) : '0;
        sol_wdata = {nr_new, ksss_pkg::sat32(sc_i_sum)};
      end
      S_UPD: begin
        sol_we    = mul_rsp.done && k == 3'd3;
        sol_waddr = row_i32[RW-1:0];
        sol_wdata = {nr_new, ksss_pkg::sat32(upd_i_sum)};
      end
      default: ;
    endcase
  end

  function automatic logic [RW-1:0] erow32_reg_addr(input logic [9:0] r);
    logic [31:0] w;
    w = 32'(r);
    return w[RW-1:0];
  endfunction

  // Memory arrays
  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem[cs_waddr] <= in_ch.col_start;
    end
    if (cs_re) begin
      cs_q <= cs_mem[cs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_addr_w] <= {in_ch.entry_row, in_ch.entry_value};
    end
    if (ent_re) begin
      ent_q <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= {in_ch.rhs_re, in_ch.rhs_im, in_ch.mass_diag, in_ch.row_norm_sq};
    end
    if (row_re) begin
      row_q <= row_mem[row_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sol_we) begin
      sol_mem[sol_waddr] <= sol_wdata;
    end
    if (sol_re) begin
      sol_q <= sol_mem[sol_raddr];
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op_busy   <= 1'b0;
      faults    <= '0;
      out_valid <= 1'b0;
      k         <= '0;
      fwd       <= 1'b1;
      scat      <= 1'b0;
    end else begin
      faults <= faults | {nz_hit, sat_hit};
      if (mul_req.start || div_req.start) begin
        op_busy <= 1'b1;
      end else if (op_done) begin
        op_busy <= 1'b0;
      end
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (cmd == ksss_pkg::CMD_RUN) begin
              fwd   <= 1'b1;
              state <= (n_eff == '0) ? S_DONE : S_ROW_A;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        S_ROW_A: state <= S_ROW_B;
        S_ROW_B: begin
          if (row_norm_q == '0) begin
            if (last_row) begin
              state <= S_DONE;
            end else begin
              fwd   <= nxt_fwd;
              state <= S_ROW_A;
            end
          end else begin
            state <= S_ROW_C;
          end
        end
        S_ROW_C: begin
          k     <= '0;
          state <= S_PRE;
        end
        S_PRE: begin
          if (op_done) begin
            k <= k + 1'b1;
            if (k == 3'd5) begin
              scat  <= 1'b0;
              state <= S_EA;
            end
          end
        end
        S_EA: begin
          if (j < hi) begin
            state <= S_EB;
          end else if (!scat) begin
            k     <= '0;
            state <= S_SCALE;
          end else if (last_row) begin
            state <= S_DONE;
          end else begin
            fwd   <= nxt_fwd;
            state <= S_ROW_A;
          end
        end
        S_EB: state <= ent_ok ? S_EC : S_EA;
        S_EC: begin
          k     <= '0;
          state <= S_ED;
        end
        S_ED: begin
          if (op_done) begin
            k <= k + 1'b1;
            if (k == 3'd1) begin
              state <= S_EA;
            end
          end
        end
        S_SCALE: begin
          if (op_done) begin
            if (k == 3'd3) begin
              k     <= '0;
              state <= S_UPD;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_UPD: begin
          if (op_done) begin
            k <= k + 1'b1;
            if (k == 3'd3) begin
              scat  <= 1'b1;
              state <= S_EA;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          idx_reg <= in_ch.index;
          n_rows  <= n_eff;
          row_i   <= '0;
          if (cmd != ksss_pkg::CMD_RUN) begin
            out_index   <= in_ch.index;
            out_is_read <= (cmd == ksss_pkg::CMD_READ) && ld_row_ok;
            out_done    <= 1'b0;
            out_faults  <= faults;
          end
        end
      end
      S_ROW_B: begin
        rhs_re <= row_q.rhs_re;
        rhs_im <= row_q.rhs_im;
        mass   <= row_q.mass;
        norm   <= row_q.norm;
        x_re_i <= sol_q.re;
        x_im_i <= sol_q.im;
        lo_raw <= cs_q;
        if (row_norm_q == '0 && !last_row) begin
          row_i <= nxt_i;
        end
      end
      S_ROW_C: begin
        lo <= clamp_nz(lo_raw);
        hi <= clamp_nz(cs_q);
      end
      S_PRE: begin
        if (op_done) begin
          case (k)
            3'd0:    sbr   <= mres;
            3'd1:    sbi   <= mres;
            3'd2:    acc_r <= -64'(rhs_re) - 64'(mres);
            3'd3:    acc_r <= acc_r + 64'(mres);
            3'd4:    acc_i <= -64'(rhs_im) - 64'(mres);
            default: begin
              acc_i <= acc_i - 64'(mres);
              j     <= lo;
            end
          endcase
        end
      end
      S_EA: begin
        if (!(j < hi) && scat && !last_row) begin
          row_i <= nxt_i;
        end
      end
      S_EB: begin
        e_row <= ent_q.row;
        e_val <= ent_q.val;
        if (!ent_ok) begin
          j <= j + 1'b1;
        end
      end
      S_EC: begin
        xr <= sol_q.re;
        xi <= sol_q.im;
      end
      S_ED: begin
        if (op_done) begin
          if (k == 3'd1) begin
            j <= j + 1'b1;
          end
          if (scat) begin
            if (k == 3'd0) begin
              nr_new <= ksss_pkg::sat32(sc_r_sum);
            end
          end else if (k == 3'd0) begin
            acc_r <= acc_r + 64'(mres);
          end else begin
            acc_i <= acc_i + 64'(mres);
          end
        end
      end
      S_SCALE: begin
        if (op_done) begin
          case (k)
            3'd0:    num_reg <= mul_rsp.prod;
            3'd1:    sr      <= dres;
            3'd2:    num_reg <= mul_rsp.prod;
            default: si      <= dres;
          endcase
        end
      end
      S_UPD: begin
        if (op_done) begin
          case (k)
            3'd0:    u_tmp  <= mres;
            3'd1:    nr_new <= ksss_pkg::sat32(upd_r_sum);
            3'd2:    u_tmp  <= mres;
            default: j      <= lo;
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_index   <= idx_reg;
          out_is_read <= 1'b0;
          out_done    <= 1'b1;
          out_faults  <= faults;
        end
      end
      default: ;
    endcase
  end

  // Result channel
  assign out_ch.valid        = out_valid;
  assign out_ch.result_index = out_index;
  assign out_ch.result_x_re  = out_is_read ? sol_q.re : '0;
  assign out_ch.result_x_im  = out_is_read ? sol_q.im : '0;
  assign out_ch.sweep_done   = out_done;
  assign out_ch.fault_flags  = out_faults;

  // A unit only answers an operation that the sequencer issued
  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    op_done |-> op_busy)
    else $error("arithmetic result without a pending operation");

  // Results arrive only in states that consume them
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    op_done |-> (state == S_PRE || state == S_ED || state == S_SCALE || state == S_UPD))
    else $error("arithmetic result outside an arithmetic state");

  // Fault flags are sticky until reset
  a_faults_sticky: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((faults & $past(faults)) == $past(faults)))
    else $error("sticky fault bit cleared");

  // A run with active rows starts at the first row
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd == ksss_pkg::CMD_RUN && n_eff != '0) |=>
      (state == S_ROW_A && row_i == '0 && fwd))
    else $error("run did not start at row zero");

endmodule

[rtl/ksss_mul.sv]
// Shared 32x32 multiplier with fixed-point rounding and saturation, through operand, product and result registers.
module ksss_mul #(
  parameter int FRAC_BITS = ksss_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ksss_pkg::mul_req_t req,
  output ksss_pkg::mul_rsp_t rsp
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic               v1, v2;
  logic               raw1, raw2;
  logic signed [31:0] a1, b1;
  logic signed [63:0] p2;
  logic signed [63:0] rnd;
  logic signed [63:0] shf;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      v1       <= req.start;
      v2       <= v1;
      rsp.done <= v2;
    end
  end

  // Operand, product and result registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      a1   <= req.a;
      b1   <= req.b;
      raw1 <= req.raw;
    end
    if (v1) begin
      p2   <= 64'(a1) * 64'(b1);
      raw2 <= raw1;
    end
    if (v2) begin
      rsp.prod <= p2;
      rsp.res  <= ksss_pkg::sat32(shf);
      rsp.sat  <= !raw2 && ksss_pkg::ovf32(shf);
    end
  end

  // Round to nearest, ties up, then floor shift
  assign rnd = p2 + HALF;
  assign shf = rnd >>> FRAC_BITS;

endmodule

[rtl/ksss_div.sv]
// Radix-2 restoring divider for the relaxation scaling, rounded to nearest with ties away from zero, saturated.
module ksss_div (
  input  logic               clk,
  input  logic               rst,
  input  ksss_pkg::div_req_t req,
  output ksss_pkg::div_rsp_t rsp
);

  localparam int DW = ksss_pkg::DIV_W;
  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [32:0]   rem;
  logic [31:0]   md;
  logic          neg;

  logic signed [63:0] num_s;
  logic signed [31:0] den_s;
  logic [63:0]        mn;
  logic [31:0]        md_in;
  logic [63:0]        dvd_in;
  logic [32:0]        trial;
  logic               fits;
  logic [63:0]        q64;
  logic signed [63:0] qs;

  assign num_s  = req.num;
  assign den_s  = req.den;
  assign mn     = num_s[63] ? 64'(-num_s) : 64'(num_s);
  assign md_in  = den_s[31] ? 32'(-den_s) : 32'(den_s);
  assign dvd_in = mn + 64'(md_in >> 1);

  // One quotient bit per step
  assign trial = {rem[31:0], dvd[DW-1]};
  assign fits  = trial >= {1'b0, md};

  assign q64 = 64'(dvd);
  assign qs  = neg ? -$signed(q64) : $signed(q64);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy     <= 1'b0;
        rsp.done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= dvd_in[DW-1:0];
      rem <= '0;
      md  <= md_in;
      neg <= num_s[63] != den_s[31];
      cnt <= CW'(DW);
    end else if (busy && cnt != '0) begin
      rem <= fits ? (trial - {1'b0, md}) : trial;
      dvd <= {dvd[DW-2:0], fits};
      cnt <= cnt - 1'b1;
    end else if (busy) begin
      rsp.res <= ksss_pkg::sat32(qs);
      rsp.sat <= ksss_pkg::ovf32(qs);
    end
  end

endmodule
